[hdl/bte_pkg.sv]
`default_nettype none

package bte_pkg;

  // Image size limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 4096;

  // Configuration field widths
  localparam int WIDTH_W  = 9;
  localparam int HEIGHT_W = 13;
  localparam int CFG_DW   = 13;
  localparam int CFG_IW   = 2;

  // Position and cell store geometry
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CELL_SLOTS = (MAX_WIDTH + 1) / 2;
  localparam int CELL_AW    = $clog2(CELL_SLOTS);

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // UTF-8 framing of U+2800
  localparam logic [7:0] UTF8_LEAD     = 8'hE2;
  localparam logic [7:0] UTF8_MID_BASE = 8'hA0;
  localparam logic [7:0] UTF8_TAIL_BASE = 8'h80;

  // Per-pixel request from the scan counter to the cell pipeline
  typedef struct packed {
    logic [CELL_AW-1:0] slot;
    logic [7:0]         weight;
    logic               emit;
    logic               last;
  } scan_req_t;

  // Standard braille dot weight for a pixel inside its 2x4 cell
  function automatic logic [7:0] dot_weight(input logic [1:0] row_lsb,
                                            input logic       col_lsb);
    logic [7:0] w;
    case ({row_lsb, col_lsb})
      3'b000:  w = 8'h01;
      3'b001:  w = 8'h08;
      3'b010:  w = 8'h02;
      3'b011:  w = 8'h10;
      3'b100:  w = 8'h04;
      3'b101:  w = 8'h20;
      3'b110:  w = 8'h40;
      3'b111:  w = 8'h80;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/bte_scan.sv]
`default_nettype none

module bte_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bte_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [bte_pkg::CFG_DW-1:0]    cfg_data,
  input  wire logic                          advance,
  input  wire logic [7:0]                    pixel_value,
  output bte_pkg::scan_req_t                 req
);
  import bte_pkg::*;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WIDTH_W-1:0]  col_p1;
  logic [HEIGHT_W-1:0] row_p1;
  logic                last_col;
  logic                last_row;

  // Hold the size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(MAX_WIDTH);
      height_r <= HEIGHT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Detect the last column and row of the image
  assign col_p1   = WIDTH_W'(col_r) + WIDTH_W'(1);
  assign row_p1   = HEIGHT_W'(row_r) + HEIGHT_W'(1);
  assign last_col = col_p1 >= w_eff;
  assign last_row = row_p1 >= h_eff;

  // Build the request for the current pixel
  always_comb begin
    req.slot   = col_r[COL_W-1:1];
    req.weight = (pixel_value != 8'h00) ? dot_weight(row_r[1:0], col_r[0]) : 8'h00;
    req.emit   = ((row_r[1:0] == 2'b11) || last_row) && (col_r[0] || last_col);
    req.last   = last_row && last_col;
  end

  // Advance the raster position, wrap at the end of a row and of the image
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_p1[ROW_W-1:0];
    end else begin
      col_nxt = col_p1[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/bte_cell_store.sv]
`default_nettype none

module bte_cell_store (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic [bte_pkg::CELL_AW-1:0]   rd_addr,
  input  wire logic                          wr_en,
  input  wire logic [bte_pkg::CELL_AW-1:0]   wr_addr,
  input  wire logic [7:0]                    wr_data,
  output logic [7:0]                         rd_data
);
  import bte_pkg::*;

  logic [7:0]            cell_mem_r [CELL_SLOTS];
  logic [CELL_SLOTS-1:0] vld_r;
  logic [7:0]            rd_q_r;
  logic                  rd_vld_r;
  logic                  fwd_r;
  logic [7:0]            fwd_data_r;

  // Write the band memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold the data while no new read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= cell_mem_r[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
        fwd_r    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // Forward a write that lands on the entry being read in the same cycle
  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data = 8'h00;
    end
  end

endmodule

`default_nettype wire

[hdl/image_to_braille_text_top.sv]
// Braille image encoder.
// Input channel: one 8-bit pixel per item in raster order (in_valid/in_ready);
// a nonzero pixel sets its dot in the 2x4 braille cell that holds it.
// Output channel: one item per completed cell (out_valid/out_ready), carrying
// the three UTF-8 bytes of U+2800 plus the pattern, the pattern itself and a
// flag on the final cell of the image. Cells come out in row-major order.
// Configuration: cfg_wr_en/cfg_index/cfg_data write image_width (index 0)
// and image_height (index 1); write them only while the block is idle.
// Throughput: one pixel per clock while no finished cell waits on a stalled
// output. The band of cell patterns lives in a 128-entry memory, read when a
// pixel is accepted and updated when it leaves stage one; a write to the entry
// being read in the same cycle is forwarded, so no bubble is needed. If the
// receiver stalls, a cell's result waits in the output register and a pixel
// that completes another cell stalls the input until it drains.
// Reset: positions go to zero, width to 256, height to 1, all cells read as
// empty at once; no clearing pass is needed.
`default_nettype none

module image_to_braille_text_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bte_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [bte_pkg::CFG_DW-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_pixel_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_utf8_lead,
  output logic [7:0]                         out_utf8_middle,
  output logic [7:0]                         out_utf8_tail,
  output logic [7:0]                         out_dot_pattern,
  output logic                               out_last_cell
);
  import bte_pkg::*;

  scan_req_t          req;
  logic               in_accept;
  logic               s1_valid_r;
  scan_req_t          s1_req_r;
  logic               s1_go;
  logic [7:0]         old_pattern;
  logic [7:0]         merged;
  logic               out_valid_r;
  logic [7:0]         pattern_r;
  logic               last_r;

  // Track raster position and decode the cell for the incoming pixel
  bte_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (in_accept),
    .pixel_value (in_pixel_value),
    .req         (req)
  );

  // Band store: read on accept, write back when the item leaves stage one
  bte_cell_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (req.slot),
    .wr_en   (s1_go),
    .wr_addr (s1_req_r.slot),
    .wr_data (s1_req_r.emit ? 8'h00 : merged),
    .rd_data (old_pattern)
  );

  // Merge the dot into the stored pattern
  assign merged = old_pattern | s1_req_r.weight;

  // Advance stage one unless its result would overwrite a stalled output
  assign s1_go     = s1_valid_r && (!s1_req_r.emit || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= req;
    end
  end

  // Hold a finished cell until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_req_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_req_r.emit) begin
      pattern_r <= merged;
      last_r    <= s1_req_r.last;
    end
  end

  // Frame the pattern as UTF-8
  assign out_valid       = out_valid_r;
  assign out_utf8_lead   = UTF8_LEAD;
  assign out_utf8_middle = UTF8_MID_BASE | {6'b000000, pattern_r[7:6]};
  assign out_utf8_tail   = UTF8_TAIL_BASE | {2'b00, pattern_r[5:0]};
  assign out_dot_pattern = pattern_r;
  assign out_last_cell   = last_r;

endmodule

`default_nettype wire

[hdl/bte_checker.sv]
`default_nettype none

module bte_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_utf8_lead,
  input  wire logic [7:0] out_utf8_middle,
  input  wire logic [7:0] out_utf8_tail,
  input  wire logic [7:0] out_dot_pattern,
  input  wire logic       out_last_cell
);

  // No item right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dot_pattern)
      && $stable(out_last_cell))
    else $error("stalled result changed");

  // UTF-8 bytes agree with the pattern
  a_utf8_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_utf8_lead == 8'hE2
      && out_utf8_middle == {6'b101000, out_dot_pattern[7:6]}
      && out_utf8_tail == {2'b10, out_dot_pattern[5:0]})
    else $error("UTF-8 bytes do not match dot pattern");

endmodule

bind image_to_braille_text_top bte_checker u_bte_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_utf8_lead   (out_utf8_lead),
  .out_utf8_middle (out_utf8_middle),
  .out_utf8_tail   (out_utf8_tail),
  .out_dot_pattern (out_dot_pattern),
  .out_last_cell   (out_last_cell)
);

`default_nettype wire

[bench/braille_cell_checker.sv]
`timescale 1ns / 1ps

module braille_cell_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bte_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bte_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 in_pixel_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [7:0]                 out_utf8_lead,
  input  logic [7:0]                 out_utf8_middle,
  input  logic [7:0]                 out_utf8_tail,
  input  logic [7:0]                 out_dot_pattern,
  input  logic                       out_last_cell,
  output int unsigned                failures,
  output int unsigned                pending
);
  import bte_pkg::*;

  // Dot bit per position in a cell, byte k = {row[1:0], col[0]}
  localparam logic [63:0] DOT_BITS = 64'h8040_2004_1002_0801;
  localparam int unsigned EXP_DEPTH = 256;

  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] middle;
    logic [7:0] tail;
    logic [7:0] pattern;
    logic       last;
  } braille_cell_t;

  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [7:0]          band [CELL_SLOTS];
  int unsigned         col_pos;
  int unsigned         row_pos;
  int unsigned         fail_count;
  braille_cell_t       exp_fifo [EXP_DEPTH];
  logic [7:0]          exp_head;
  logic [7:0]          exp_tail;
  int unsigned         exp_count;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Append a predicted cell to the expectation FIFO
  function automatic void store_expected(input braille_cell_t entry);
    exp_fifo[exp_tail] = entry;
    exp_tail = exp_tail + 8'd1;
    exp_count = exp_count + 1;
  endfunction

  // Merge one pixel into its cell; queue the cell when the pixel completes it
  task automatic encode_pixel(input logic [7:0] px);
    int unsigned   w;
    int unsigned   h;
    int unsigned   slot;
    int unsigned   dot_idx;
    bit            at_last_col;
    bit            at_last_row;
    logic [7:0]    pat;
    braille_cell_t exp_entry;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    at_last_col = (col_pos + 1) >= w;
    at_last_row = (row_pos + 1) >= h;
    slot = col_pos >> 1;
    if (slot >= CELL_SLOTS) slot = CELL_SLOTS - 1;
    dot_idx = (row_pos % 4) * 2 + (col_pos % 2);
    if (px != 8'd0) band[slot] = band[slot] | DOT_BITS[8*dot_idx +: 8];
    if (((row_pos % 4) == 3 || at_last_row) && ((col_pos % 2) == 1 || at_last_col)) begin
      pat = band[slot];
      exp_entry.lead = UTF8_LEAD;
      exp_entry.middle = UTF8_MID_BASE | {6'd0, pat[7:6]};
      exp_entry.tail = UTF8_TAIL_BASE | {2'd0, pat[5:0]};
      exp_entry.pattern = pat;
      exp_entry.last = at_last_row && at_last_col;
      store_expected(exp_entry);
      band[slot] = 8'd0;
    end
    // Advance the raster position, wrapping at the end of a row and of the image
    if (at_last_col) begin
      col_pos = 0;
      row_pos = at_last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // Compare one emitted cell with the oldest queued one
  task automatic check_cell();
    braille_cell_t exp_cell;
    braille_cell_t got;
    got = '{out_utf8_lead, out_utf8_middle, out_utf8_tail, out_dot_pattern, out_last_cell};
    if (exp_count == 0) begin
      fail_count = fail_count + 1;
      if (fail_count <= 10)
        $display("unexpected cell: lead %h mid %h tail %h dots %h last %b",
                 got.lead, got.middle, got.tail, got.pattern, got.last);
    end else begin
      exp_cell = exp_fifo[exp_head];
      exp_head = exp_head + 8'd1;
      exp_count = exp_count - 1;
      if (got.lead !== exp_cell.lead || got.middle !== exp_cell.middle ||
          got.tail !== exp_cell.tail || got.pattern !== exp_cell.pattern ||
          got.last !== exp_cell.last) begin
        fail_count = fail_count + 1;
        if (fail_count <= 10)
          $display("cell mismatch: exp lead %h mid %h tail %h dots %h last %b, %s",
                   exp_cell.lead, exp_cell.middle, exp_cell.tail, exp_cell.pattern,
                   exp_cell.last, $sformatf("got lead %h mid %h tail %h dots %h last %b",
                   got.lead, got.middle, got.tail, got.pattern, got.last));
      end
    end
  endtask

  initial begin
    fail_count = 0;
    failures = 0;
    pending = 0;
  end

  // Track registers, results and pixels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 9'd256;
      height_reg = 13'd1;
      for (int i = 0; i < CELL_SLOTS; i++) band[i] = 8'd0;
      col_pos = 0;
      row_pos = 0;
      exp_head = 8'd0;
      exp_tail = 8'd0;
      exp_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_cell();
      if (in_valid && in_ready) encode_pixel(in_pixel_value);
    end
    pending <= exp_count;
    failures <= fail_count;
  end

endmodule

[bench/tb_image_to_braille_text_top.sv]
`timescale 1ns / 1ps

module tb_image_to_braille_text_top;
  import bte_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_pixel_value = 8'd0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_utf8_lead;
  logic [7:0]        out_utf8_middle;
  logic [7:0]        out_utf8_tail;
  logic [7:0]        out_dot_pattern;
  logic              out_last_cell;
  int unsigned       failures;
  int unsigned       pending;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;
  int unsigned       rx_hold = 0;

  always #5 clk = ~clk;

  image_to_braille_text_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel_value(in_pixel_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_utf8_lead(out_utf8_lead),
    .out_utf8_middle(out_utf8_middle),
    .out_utf8_tail(out_utf8_tail),
    .out_dot_pattern(out_dot_pattern),
    .out_last_cell(out_last_cell)
  );

  braille_cell_checker cell_check (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pixel_value(in_pixel_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_utf8_lead(out_utf8_lead),
    .out_utf8_middle(out_utf8_middle),
    .out_utf8_tail(out_utf8_tail),
    .out_dot_pattern(out_dot_pattern),
    .out_last_cell(out_last_cell),
    .failures(failures),
    .pending(pending)
  );

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'd0;
    if (r < 5) return 8'hFF;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Stall the result channel at random, with steady stretches now and then
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady) rx_hold <= pick_gap();
    end
    if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
  end

  // Hold the pixel until accepted, then maybe idle
  task automatic send_pixel(input logic [7:0] v);
    int unsigned gap;
    in_valid <= 1'b1;
    in_pixel_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every queued cell to come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both size registers while the block is idle
  task automatic set_size(input logic [CFG_DW-1:0] w_data, input logic [CFG_DW-1:0] h_data);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= w_data;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data <= h_data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       n;
    int unsigned       r;
    int unsigned       wi;
    int unsigned       hi;
    logic [WIDTH_W-1:0] w9;
    logic [CFG_DW-1:0] wd;
    logic [CFG_DW-1:0] hd;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: one row of 256, extreme pixel values
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'h80);
    // Zero sizes act as one, written mid-row
    set_size(13'd0, 13'd0);
    send_pixel(8'h7F);
    send_pixel(8'h00);
    send_pixel(8'h02);
    // Oversized sizes clamp to the maximum; upper data bits set
    set_size(13'h1FFF, 13'h1FFF);
    send_pixel(8'h40);
    send_pixel(8'h20);
    send_pixel(8'h10);
    // Odd width, height not a multiple of four, through an image end
    set_size(13'd3, 13'd5);
    for (int i = 0; i < 15; i++) send_pixel(i[0] ? 8'h00 : 8'hFF);

    // Random phases, mostly small images
    sent = 0;
    while (sent < 1450) begin
      r = $urandom_range(0, 99);
      if (r < 70) w9 = 9'($urandom_range(1, 10));
      else if (r < 90) w9 = 9'($urandom_range(1, 256));
      else if (r < 95) w9 = 9'd0;
      else w9 = 9'($urandom_range(257, 511));
      wd = {4'($urandom_range(0, 15)), w9};
      r = $urandom_range(0, 99);
      if (r < 70) hd = 13'($urandom_range(1, 10));
      else if (r < 85) hd = 13'($urandom_range(11, 40));
      else if (r < 90) hd = 13'd0;
      else if (r < 95) hd = 13'd4096;
      else hd = 13'($urandom_range(4097, 8191));
      set_size(wd, hd);
      tx_steady = ($urandom_range(0, 3) == 0);
      wi = clamp_dim(w9, MAX_WIDTH);
      hi = clamp_dim(hd, MAX_HEIGHT);
      if ($urandom_range(0, 4) < 3 && wi * hi <= 300) n = wi * hi * $urandom_range(1, 3);
      else n = $urandom_range(1, 60);
      if (n > 1450 - sent) n = 1450 - sent;
      repeat (n) begin
        send_pixel(pick_pixel());
        if ($urandom_range(0, 49) == 0) drain();
      end
      sent = sent + n;
    end

    // Full-width row, reaching the last column and the image end
    set_size(13'd256, 13'd1);
    tx_steady = 1'b1;
    repeat (256) send_pixel(pick_pixel());

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
